// File: src/srlr_pkg.sv
`timescale 1ns / 1ps
// srlr_pkg: shared types and constants of the stereo linear resampler
// no dependencies; imported by every module of the block
package srlr_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned STEP_W      = 22;
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;
  localparam int unsigned CFG_ADDR_W  = 1;

  localparam logic [STEP_W-1:0] RATIO_STEP_RESET = STEP_W'(65536);

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_RATIO_STEP = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MONO_MODE  = 1'd1;

  typedef struct packed {
    logic                          fin;
    logic signed [SAMPLE_BITS-1:0] right;
    logic signed [SAMPLE_BITS-1:0] left;
  } srlr_frame_t;

  typedef struct packed {
    logic valid;
    logic last;
  } srlr_emit_t;

endpackage

// File: src/srlr_front.sv
`timescale 1ns / 1ps
// srlr_front: configuration registers, input acceptance and the frame queue
// depends on srlr_pkg
module srlr_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [srlr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [srlr_pkg::STEP_W-1:0]        cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [2*srlr_pkg::SAMPLE_BITS-1:0] in_tdata,
  input  logic                               in_tlast,
  output logic [srlr_pkg::STEP_W-1:0]        ratio_step,
  output logic                               frm_valid,
  output srlr_pkg::srlr_frame_t              frm,
  input  logic                               frm_pop
);
  import srlr_pkg::*;

  logic [STEP_W-1:0] ratio_step_r;
  logic              mono_r;
  srlr_frame_t       queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] fill_r;
  logic              push;
  logic              pop;
  srlr_frame_t       push_frm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_step_r <= RATIO_STEP_RESET;
      mono_r       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RATIO_STEP: ratio_step_r <= cfg_wdata;
        REG_MONO_MODE:  mono_r       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_tready = (fill_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign pop       = frm_pop && frm_valid;

  // mono copies the first channel to both sides before queuing
  always_comb begin
    push_frm.left  = in_tdata[SAMPLE_BITS-1:0];
    push_frm.right = mono_r ? in_tdata[SAMPLE_BITS-1:0]
                            : in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    push_frm.fin   = in_tlast;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= push_frm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill_r <= fill_r + QCNT_W'(1);
        2'b01:   fill_r <= fill_r - QCNT_W'(1);
        default: fill_r <= fill_r;
      endcase
    end
  end

  assign frm_valid  = (fill_r != '0);
  assign frm        = queue_r[rd_ptr_r];
  assign ratio_step = ratio_step_r;

endmodule

// File: src/srlr_seq.sv
`timescale 1ns / 1ps
// srlr_seq: per-frame sequencer, holds the previous frame and output position
// depends on srlr_pkg; drives srlr_blend one output per cycle while adv is high
module srlr_seq #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [srlr_pkg::STEP_W-1:0]            ratio_step,
  input  logic                                   frm_valid,
  input  srlr_pkg::srlr_frame_t                  frm,
  output logic                                   frm_pop,
  input  logic                                   adv,
  output srlr_pkg::srlr_emit_t                   req,
  output logic signed [srlr_pkg::SAMPLE_BITS-1:0] a_l,
  output logic signed [srlr_pkg::SAMPLE_BITS-1:0] a_r,
  output logic signed [srlr_pkg::SAMPLE_BITS-1:0] b_l,
  output logic signed [srlr_pkg::SAMPLE_BITS-1:0] b_r,
  output logic [FRACTION_BITS-1:0]               frac
);
  import srlr_pkg::*;

  localparam int unsigned POS_W =
    ((FRACTION_BITS > STEP_W) ? FRACTION_BITS : STEP_W) + 1;
  localparam logic [POS_W-1:0] ONE = POS_W'(1) << FRACTION_BITS;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_INTERP = 3'b010,
    ST_TAIL   = 3'b100
  } seq_state_t;

  seq_state_t                    state_r, state_nxt;
  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          held_valid_r, held_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] held_l_r, held_l_nxt;
  logic signed [SAMPLE_BITS-1:0] held_r_r, held_r_nxt;
  logic signed [SAMPLE_BITS-1:0] new_l_r, new_l_nxt;
  logic signed [SAMPLE_BITS-1:0] new_r_r, new_r_nxt;
  logic                          fin_r, fin_nxt;

  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] pos_m1;
  logic [POS_W-1:0] pos_end;
  logic [CNT_W-1:0] cnt_inc;
  logic             pos_lt_one;
  logic             pos_inc_lt;
  logic             pos_m1_lt;
  logic             pos_end_lt;
  logic             room;
  logic             more_interp;
  logic             more_tail;

  always_comb begin
    pos_inc     = pos_r + POS_W'(ratio_step);
    pos_m1      = pos_r - ONE;
    pos_lt_one  = (pos_r < ONE);
    pos_inc_lt  = (pos_inc < ONE);
    pos_m1_lt   = (pos_m1 < ONE);
    // hitting the cap restarts the position at the new frame
    pos_end     = (pos_inc_lt ? ONE : pos_inc) - ONE;
    pos_end_lt  = (pos_end < ONE);
    cnt_inc     = cnt_r + CNT_W'(1);
    room        = (cnt_inc < CNT_W'(MAX_RESULTS));
    more_interp = pos_inc_lt && room;
    more_tail   = fin_r && pos_end_lt && room;
  end

  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    held_valid_nxt = held_valid_r;
    held_l_nxt     = held_l_r;
    held_r_nxt     = held_r_r;
    new_l_nxt      = new_l_r;
    new_r_nxt      = new_r_r;
    fin_nxt        = fin_r;
    frm_pop        = 1'b0;
    req            = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (frm_valid) begin
          frm_pop = 1'b1;
          cnt_nxt = '0;
          if (held_valid_r) begin
            if (pos_lt_one) begin
              state_nxt = ST_INTERP;
              new_l_nxt = frm.left;
              new_r_nxt = frm.right;
              fin_nxt   = frm.fin;
            end else begin
              // position lies beyond the new frame: no output
              held_l_nxt = frm.left;
              held_r_nxt = frm.right;
              if (frm.fin && pos_m1_lt) begin
                state_nxt = ST_TAIL;
                pos_nxt   = pos_m1;
              end else if (frm.fin) begin
                held_valid_nxt = 1'b0;
                pos_nxt        = '0;
              end else begin
                pos_nxt = pos_m1;
              end
            end
          end else begin
            // first frame of a stream
            held_l_nxt     = frm.left;
            held_r_nxt     = frm.right;
            held_valid_nxt = 1'b1;
            pos_nxt        = '0;
            if (frm.fin) begin
              state_nxt = ST_TAIL;
            end
          end
        end
      end
      ST_INTERP: begin
        if (adv) begin
          req.valid = 1'b1;
          cnt_nxt   = cnt_inc;
          if (more_interp) begin
            pos_nxt = pos_inc;
          end else begin
            held_l_nxt = new_l_r;
            held_r_nxt = new_r_r;
            if (more_tail) begin
              state_nxt = ST_TAIL;
              pos_nxt   = pos_end;
            end else begin
              req.last  = 1'b1;
              state_nxt = ST_IDLE;
              if (fin_r) begin
                held_valid_nxt = 1'b0;
                pos_nxt        = '0;
              end else begin
                pos_nxt = pos_end;
              end
            end
          end
        end
      end
      ST_TAIL: begin
        if (adv) begin
          req.valid = 1'b1;
          cnt_nxt   = cnt_inc;
          if (more_interp) begin
            pos_nxt = pos_inc;
          end else begin
            req.last       = 1'b1;
            state_nxt      = ST_IDLE;
            held_valid_nxt = 1'b0;
            pos_nxt        = '0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_r        <= '0;
      cnt_r        <= '0;
      held_valid_r <= 1'b0;
      held_l_r     <= '0;
      held_r_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      cnt_r        <= cnt_nxt;
      held_valid_r <= held_valid_nxt;
      held_l_r     <= held_l_nxt;
      held_r_r     <= held_r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_l_r <= new_l_nxt;
    new_r_r <= new_r_nxt;
    fin_r   <= fin_nxt;
  end

  // tail outputs are the held frame blended with itself at zero weight
  assign a_l  = held_l_r;
  assign a_r  = held_r_r;
  assign b_l  = (state_r == ST_TAIL) ? held_l_r : new_l_r;
  assign b_r  = (state_r == ST_TAIL) ? held_r_r : new_r_r;
  assign frac = (state_r == ST_TAIL) ? '0 : pos_r[FRACTION_BITS-1:0];

endmodule

// File: src/srlr_blend.sv
`timescale 1ns / 1ps
// srlr_blend: two-lane interpolation pipeline (multiply, then add/round/clamp)
// and the output register; depends on srlr_pkg
module srlr_blend #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  srlr_pkg::srlr_emit_t                    req,
  input  logic signed [srlr_pkg::SAMPLE_BITS-1:0] a_l,
  input  logic signed [srlr_pkg::SAMPLE_BITS-1:0] a_r,
  input  logic signed [srlr_pkg::SAMPLE_BITS-1:0] b_l,
  input  logic signed [srlr_pkg::SAMPLE_BITS-1:0] b_r,
  input  logic [FRACTION_BITS-1:0]                frac,
  output logic                                    adv,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [2*srlr_pkg::SAMPLE_BITS-1:0]      out_tdata,
  output logic                                    out_tlast
);
  import srlr_pkg::*;

  localparam int unsigned PROD_W = SAMPLE_BITS + FRACTION_BITS + 2;
  localparam int unsigned ACC_W  = PROD_W + 1;
  localparam int unsigned Q_W    = ACC_W - FRACTION_BITS;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRACTION_BITS - 1);
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((1 << SAMPLE_BITS) - 1);

  logic signed [SAMPLE_BITS:0]   diff_l, diff_r;
  logic signed [FRACTION_BITS:0] frac_s;
  logic signed [PROD_W-1:0]      prod_l, prod_r;
  logic                          s1_valid_r, s1_last_r;
  logic signed [PROD_W-1:0]      s1_prod_l_r, s1_prod_r_r;
  logic [SAMPLE_BITS-1:0]        s1_base_l_r, s1_base_r_r;
  logic                          out_valid_r, out_last_r;
  logic [SAMPLE_BITS-1:0]        out_l_r, out_r_r;

  // base + diff * frac, rounded half up, clamped, back to two's complement
  function automatic logic [SAMPLE_BITS-1:0] finish(
    input logic signed [PROD_W-1:0] prod,
    input logic [SAMPLE_BITS-1:0]   base
  );
    logic signed [ACC_W-1:0] acc;
    logic signed [Q_W-1:0]   q;
    logic [SAMPLE_BITS-1:0]  u;
    acc = ACC_W'(prod) + $signed(ACC_W'({base, {FRACTION_BITS{1'b0}}}))
        + $signed(HALF);
    q   = acc[ACC_W-1:FRACTION_BITS];
    if (q < 0) begin
      u = '0;
    end else if (q > Q_MAX) begin
      u = '1;
    end else begin
      u = q[SAMPLE_BITS-1:0];
    end
    return {~u[SAMPLE_BITS-1], u[SAMPLE_BITS-2:0]};
  endfunction

  assign adv = !out_valid_r || out_tready;

  always_comb begin
    diff_l = $signed({b_l[SAMPLE_BITS-1], b_l}) - $signed({a_l[SAMPLE_BITS-1], a_l});
    diff_r = $signed({b_r[SAMPLE_BITS-1], b_r}) - $signed({a_r[SAMPLE_BITS-1], a_r});
    frac_s = $signed({1'b0, frac});
    prod_l = PROD_W'(diff_l) * PROD_W'(frac_s);
    prod_r = PROD_W'(diff_r) * PROD_W'(frac_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= req.valid;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last_r   <= req.last;
      s1_prod_l_r <= prod_l;
      s1_prod_r_r <= prod_r;
      // offset binary keeps the base term non-negative
      s1_base_l_r <= {~a_l[SAMPLE_BITS-1], a_l[SAMPLE_BITS-2:0]};
      s1_base_r_r <= {~a_r[SAMPLE_BITS-1], a_r[SAMPLE_BITS-2:0]};
      out_last_r  <= s1_last_r;
      out_l_r     <= finish(s1_prod_l_r, s1_base_l_r);
      out_r_r     <= finish(s1_prod_r_r, s1_base_r_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r_r, out_l_r};
  assign out_tlast  = out_last_r;

endmodule

// File: src/stereo_linear_resampler_unit.sv
`timescale 1ns / 1ps
// stereo_linear_resampler_unit: top level of the stereo linear resampler
// depends on srlr_pkg, srlr_front, srlr_seq, srlr_blend
//
//   channel   direction  handshake          payload
//   in_*      input      tvalid/tready      tdata = left_in, right_in; tlast = final_frame
//   out_*     output     tvalid/tready      tdata = left_out, right_out; tlast = run_end
//   cfg_*     input      we only            addr 0 ratio_step, addr 1 mono_mode
//
// a frame takes a classify step in the sequencer plus one issue step per output, with
// at most 64 outputs per frame; the interpolation loop issues one output per cycle
// unless out_tready stalls it, and results pass the multiply stage and output register
// reset: synchronous on rst_n low, clears the queue, drops the held frame,
// sets ratio_step to 1.0 and mono_mode to 0
// out_tready low freezes the output pipeline; a full two-frame queue drops in_tready
module stereo_linear_resampler_unit #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [srlr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [srlr_pkg::STEP_W-1:0]        cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [2*srlr_pkg::SAMPLE_BITS-1:0] in_tdata,   // left_in, right_in
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [2*srlr_pkg::SAMPLE_BITS-1:0] out_tdata,  // left_out, right_out
  output logic                               out_tlast
);
  import srlr_pkg::*;

  logic [STEP_W-1:0]             ratio_step;
  logic                          frm_valid;
  srlr_frame_t                   frm;
  logic                          frm_pop;
  logic                          adv;
  srlr_emit_t                    req;
  logic signed [SAMPLE_BITS-1:0] a_l, a_r, b_l, b_r;
  logic [FRACTION_BITS-1:0]      frac;

  srlr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .ratio_step (ratio_step),
    .frm_valid  (frm_valid),
    .frm        (frm),
    .frm_pop    (frm_pop)
  );

  srlr_seq #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .ratio_step (ratio_step),
    .frm_valid  (frm_valid),
    .frm        (frm),
    .frm_pop    (frm_pop),
    .adv        (adv),
    .req        (req),
    .a_l        (a_l),
    .a_r        (a_r),
    .b_l        (b_l),
    .b_r        (b_r),
    .frac       (frac)
  );

  srlr_blend #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .a_l        (a_l),
    .a_r        (a_r),
    .b_l        (b_l),
    .b_r        (b_r),
    .frac       (frac),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: src/srlr_checker.sv
`timescale 1ns / 1ps
// srlr_checker: port-level assertions for stereo_linear_resampler_unit
// depends on srlr_pkg; attached to the top level by the bind below
module srlr_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [2*srlr_pkg::SAMPLE_BITS-1:0] out_tdata,
  input logic                               out_tlast
);
  import srlr_pkg::*;

  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out transaction dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("out payload changed while stalled");

  a_reset_no_output: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_reset_queue_empty: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready right after reset");

  // an output needs the classify and issue states and the multiply stage after reset
  a_output_latency: assert property (@(posedge clk)
    !rst_n ##1 rst_n |=> !out_tvalid)
    else $error("output appeared too soon after reset");

endmodule

bind stereo_linear_resampler_unit srlr_checker u_srlr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// File: test/stereo_linear_resampler_unit_tb.sv
`timescale 1ns / 1ps
// stereo_linear_resampler_unit_tb: self-checking bench for the stereo linear resampler
// depends on srlr_pkg and stereo_linear_resampler_unit; directed table, then random streams
module stereo_linear_resampler_unit_tb;
  import srlr_pkg::*;

  localparam int unsigned ONE_POS = 1 << 16;   // one input frame in position units
  localparam int PREDICTED     = -1;
  localparam int SETTLE_CYCLES = 80;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int LONG_HOLD     = 400;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 16;
  localparam logic [15:0] S_MAX = 16'h7FFF;
  localparam logic [15:0] S_MIN = 16'h8000;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic        run_end;
  } stereo_sample_t;

  typedef enum logic {ROW_FRAME, ROW_CFG} row_kind_t;

  // n_typed >= 0: results typed in by hand, first one then all the rest equal
  typedef struct {
    row_kind_t              kind;
    logic [CFG_ADDR_W-1:0]  addr;
    logic [STEP_W-1:0]      value;
    logic [15:0]            left;
    logic [15:0]            right;
    logic                   fin;
    int                     n_typed;
    logic [15:0]            first_l;
    logic [15:0]            first_r;
    logic [15:0]            rest_l;
    logic [15:0]            rest_r;
  } script_row_t;

  logic                               clk        = 1'b0;
  logic                               rst_n      = 1'b0;
  logic                               cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]              cfg_addr   = '0;
  logic [STEP_W-1:0]                  cfg_wdata  = '0;
  logic                               in_tvalid  = 1'b0;
  logic                               in_tready;
  logic [2*SAMPLE_BITS-1:0]           in_tdata   = '0;  // left_in, right_in
  logic                               in_tlast   = 1'b0;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [2*SAMPLE_BITS-1:0]           out_tdata;        // left_out, right_out
  logic                               out_tlast;

  // predictor copy of the block's registers and state
  logic [STEP_W-1:0] step_q16 = RATIO_STEP_RESET;
  logic              mono_q   = 1'b0;
  logic [15:0]       held_l   = '0;
  logic [15:0]       held_r   = '0;
  logic              held_ok  = 1'b0;
  logic [31:0]       phase_pos = '0;

  stereo_sample_t pending_outputs[$];
  stereo_sample_t predicted_batch[$];
  script_row_t    dir_script[$];
  int             fail_count     = 0;
  int             mismatch_count = 0;
  int             tx_calm        = 0;
  int             rx_calm        = 0;
  bit             rx_hold_req    = 1'b0;

  stereo_linear_resampler_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  // weighted mix in offset binary, rounded half up, clamped
  function automatic logic [15:0] lerp_sample(logic [15:0] a, logic [15:0] b,
                                              logic [31:0] frac);
    logic [63:0] acc;
    acc = 64'(a ^ S_MIN) * 64'(ONE_POS - frac) + 64'(b ^ S_MIN) * 64'(frac)
        + 64'(ONE_POS / 2);
    acc = acc >> 16;
    if (acc > 64'hFFFF) acc = 64'hFFFF;
    return acc[15:0] ^ S_MIN;
  endfunction

  // fills predicted_batch with the outputs one accepted frame causes
  task automatic resample_frame(logic [15:0] l_in, logic [15:0] r_in, logic fin);
    logic [15:0]    nl;
    logic [15:0]    nr;
    stereo_sample_t s;
    predicted_batch.delete();
    nl = l_in;
    nr = mono_q ? l_in : r_in;
    s.run_end = 1'b0;
    if (held_ok) begin
      while (phase_pos < ONE_POS) begin
        if (predicted_batch.size() >= MAX_RESULTS) begin
          // cap hit: skip the rest and restart at the new frame
          phase_pos = ONE_POS;
          break;
        end
        s.left  = lerp_sample(held_l, nl, phase_pos);
        s.right = lerp_sample(held_r, nr, phase_pos);
        predicted_batch.push_back(s);
        phase_pos += step_q16;
      end
      phase_pos -= ONE_POS;
    end else begin
      phase_pos = '0;
    end
    held_l  = nl;
    held_r  = nr;
    held_ok = 1'b1;
    if (fin) begin
      while (phase_pos < ONE_POS && predicted_batch.size() < MAX_RESULTS) begin
        s.left  = held_l;
        s.right = held_r;
        predicted_batch.push_back(s);
        phase_pos += step_q16;
      end
      held_ok   = 1'b0;
      phase_pos = '0;
    end
    if (predicted_batch.size() > 0)
      predicted_batch[predicted_batch.size()-1].run_end = 1'b1;
  endtask

  // per-item wait, with stretches of back-to-back traffic
  function automatic int draw_gap(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_frame(logic [15:0] l, logic [15:0] r, logic fin, int n = PREDICTED,
                           logic [15:0] fl = '0, logic [15:0] fr = '0,
                           logic [15:0] rl = '0, logic [15:0] rr = '0);
    script_row_t row;
    row.kind = ROW_FRAME;  row.addr = '0;     row.value = '0;
    row.left = l;          row.right = r;     row.fin = fin;
    row.n_typed = n;
    row.first_l = fl;      row.first_r = fr;  row.rest_l = rl;  row.rest_r = rr;
    dir_script.push_back(row);
  endtask

  task automatic add_cfg(logic [CFG_ADDR_W-1:0] addr, logic [STEP_W-1:0] value);
    script_row_t row;
    row = '{kind: ROW_CFG, addr: addr, value: value, n_typed: PREDICTED, default: '0};
    dir_script.push_back(row);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [STEP_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (addr == REG_RATIO_STEP) step_q16 = value;
    else if (addr == REG_MONO_MODE) mono_q = value[0];
  endtask

  task automatic send_frame(script_row_t row);
    int             gap;
    stereo_sample_t s;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {row.right, row.left};
    in_tlast  <= row.fin;
    do @(posedge clk); while (!in_tready);
    resample_frame(row.left, row.right, row.fin);
    if (row.n_typed == PREDICTED) begin
      foreach (predicted_batch[k]) pending_outputs.push_back(predicted_batch[k]);
    end else begin
      for (int k = 0; k < row.n_typed; k++) begin
        s.left    = (k == 0) ? row.first_l : row.rest_l;
        s.right   = (k == 0) ? row.first_r : row.rest_r;
        s.run_end = (k == row.n_typed - 1);
        pending_outputs.push_back(s);
      end
    end
  endtask

  // stop offering, wait for every expected result, then let the block settle
  task automatic wait_idle();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (pending_outputs.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_outputs.size() != 0) begin
      fail_count += pending_outputs.size();
      $display("%0d expected results never arrived", pending_outputs.size());
      pending_outputs.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    stereo_sample_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outputs.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: left %h right %h last %b",
                   out_tdata[15:0], out_tdata[31:16], out_tlast);
      end else begin
        want = pending_outputs.pop_front();
        if (out_tdata[15:0] !== want.left || out_tdata[31:16] !== want.right ||
            out_tlast !== want.run_end) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: expected left %h right %h last %b, got %h %h %b",
                     want.left, want.right, want.run_end,
                     out_tdata[15:0], out_tdata[31:16], out_tlast);
        end
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int w;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        w = LONG_HOLD;
      end else begin
        w = draw_gap(rx_calm);
      end
      if (w > 0) begin
        out_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    script_row_t      row;
    logic [STEP_W-1:0] ratio;
    int               stream_left;

    // default settings: unit step, stereo
    add_frame(S_MAX, S_MIN, 1'b0, 0);
    add_frame(S_MIN, S_MAX, 1'b0, 1, S_MAX, S_MIN);
    add_frame(16'h0000, 16'hFFFF, 1'b1, 2, S_MIN, S_MAX, 16'h0000, 16'hFFFF);
    // lone final frame: only its own copy
    add_frame(16'h1234, 16'h5678, 1'b1, 1, 16'h1234, 16'h5678);
    add_cfg(REG_MONO_MODE, 1);
    add_frame(S_MAX, 16'h1111, 1'b0, 0);
    add_frame(S_MIN, 16'h2222, 1'b0, 1, S_MAX, S_MAX);
    add_frame(16'h4000, 16'h3333, 1'b1, 2, S_MIN, S_MIN, 16'h4000, 16'h4000);
    add_cfg(REG_MONO_MODE, 0);
    add_cfg(REG_RATIO_STEP, 22'h008000);
    add_frame(S_MAX, S_MIN, 1'b0);
    add_frame(S_MIN, S_MAX, 1'b0);
    add_frame(S_MAX, S_MAX, 1'b0);
    add_frame(S_MIN, S_MIN, 1'b1);
    add_cfg(REG_RATIO_STEP, 22'd2048);
    add_frame(16'h0001, 16'hFFFF, 1'b0);
    add_frame(S_MAX, S_MIN, 1'b1);
    // zero step runs into the result cap
    add_cfg(REG_RATIO_STEP, 22'd0);
    add_frame(16'h5555, 16'hAAAA, 1'b0);
    add_frame(16'hAAAA, 16'h5555, 1'b0);
    add_frame(S_MAX, S_MIN, 1'b1);
    // large step: position runs past the new frame, final frame emits nothing
    add_cfg(REG_RATIO_STEP, 22'd2097152);
    add_frame(16'h1000, 16'h2000, 1'b0, 0);
    add_frame(16'h3000, 16'h4000, 1'b0, 1, 16'h1000, 16'h2000);
    add_frame(16'h5000, 16'h6000, 1'b0, 0);
    add_frame(16'h7000, 16'h0800, 1'b1, 0);
    add_cfg(REG_RATIO_STEP, 22'h3FFFFF);
    add_frame(16'hFFFF, 16'h0000, 1'b0);
    add_frame(16'h0000, 16'hFFFF, 1'b1);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_script[i]) begin
      if (dir_script[i].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(dir_script[i].addr, dir_script[i].value);
      end else begin
        send_frame(dir_script[i]);
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: ratio = 22'd2048;
        1: ratio = 22'd2097152;
        2: ratio = STEP_W'($urandom_range(0, 2047));
        3: ratio = STEP_W'($urandom_range(2097153, 4194303));
        default: ratio = STEP_W'($urandom_range(16384, 262144));
      endcase
      // the hold-off phase needs outputs to back up
      if (phase == 2) ratio = STEP_W'($urandom_range(8192, 65536));
      cfg_write(REG_RATIO_STEP, ratio);
      cfg_write(REG_MONO_MODE, STEP_W'($urandom_range(0, 1)));
      if (phase == 2) rx_hold_req = 1'b1;
      stream_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (stream_left == 0) stream_left = $urandom_range(1, 8);
        row = '{kind: ROW_FRAME, n_typed: PREDICTED, default: '0};
        row.left  = pick_sample();
        row.right = pick_sample();
        row.fin   = (stream_left == 1);
        stream_left--;
        send_frame(row);
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
